FILE: sv/complex_arithmetic_unit_assert.svh
// Assertion macros shared by the complex ALU modules.
// Each expects i_clk and i_rst_n in the scope where it is used.
`ifndef COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH

// Clocked check, off while reset is held.
`define CAU_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("complex ALU assertion failed");

// Same, with a caller-supplied message string.
`define CAU_ASSERT_MSG(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

`endif

FILE: sv/cau_pkg.sv
`timescale 1ns / 1ps

package cau_pkg;

    localparam int FIELD_W = 32;            // operand and result field width
    localparam int OPND_W  = FIELD_W + 1;   // room for 1.0 at FRAC_BITS = 31
    localparam int PROD_W  = 2 * OPND_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int MAG_W   = 2 * FIELD_W;   // magnitudes of all exact results
    localparam int ACT_W   = 3;
    localparam int STAT_W  = 2;

    typedef enum logic [ACT_W-1:0] {
        ACT_ADD  = 3'd0,
        ACT_SUB  = 3'd1,
        ACT_MUL  = 3'd2,
        ACT_DIV  = 3'd3,
        ACT_CONJ = 3'd4,
        ACT_INV  = 3'd5
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_SAT     = 2'd1,
        ST_DIVZERO = 2'd2
    } t_status;

    // Internal operation class; inverse is a divide with substituted operands.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_CONJ
    } t_op;

    typedef struct packed {
        t_op                      op;
        logic signed [OPND_W-1:0] p_re;
        logic signed [OPND_W-1:0] p_im;
        logic signed [OPND_W-1:0] y_re;
        logic signed [OPND_W-1:0] y_im;
    } t_item;

endpackage

FILE: sv/cau_front.sv
`timescale 1ns / 1ps

module cau_front import cau_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic [ACT_W-1:0]          i_action,
    input  logic signed [FIELD_W-1:0] i_a_re,
    input  logic signed [FIELD_W-1:0] i_a_im,
    input  logic signed [FIELD_W-1:0] i_b_re,
    input  logic signed [FIELD_W-1:0] i_b_im,
    output t_item                     o_item
);

    localparam logic signed [OPND_W-1:0] ONE_Q = OPND_W'(1) << FRAC_BITS;

    always_comb begin
        o_item.op   = OP_NONE;
        o_item.p_re = OPND_W'(i_a_re);
        o_item.p_im = OPND_W'(i_a_im);
        o_item.y_re = OPND_W'(i_b_re);
        o_item.y_im = OPND_W'(i_b_im);
        unique case (i_action)
            ACT_ADD:  o_item.op = OP_ADD;
            ACT_SUB:  o_item.op = OP_SUB;
            ACT_MUL:  o_item.op = OP_MUL;
            ACT_DIV:  o_item.op = OP_DIV;
            ACT_CONJ: o_item.op = OP_CONJ;
            ACT_INV: begin
                // 1/a = (1 + 0i) / a
                o_item.op   = OP_DIV;
                o_item.p_re = ONE_Q;
                o_item.p_im = '0;
                o_item.y_re = OPND_W'(i_a_re);
                o_item.y_im = OPND_W'(i_a_im);
            end
            default:  o_item.op = OP_NONE;
        endcase
    end

endmodule

FILE: sv/cau_queue.sv
`timescale 1ns / 1ps
`include "complex_arithmetic_unit_assert.svh"

module cau_queue import cau_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_ready,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item            r_mem [0:DEPTH-1];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] f_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= f_next(r_wr);
            end
            if (i_pop) begin
                r_rd <= f_next(r_rd);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    `CAU_ASSERT(a_q_no_push_full, (r_count == CNT_W'(DEPTH)) |-> !i_push)
    `CAU_ASSERT(a_q_no_pop_empty, (r_count == '0) |-> !i_pop)
    `CAU_ASSERT_MSG(a_q_pop_count, (i_pop && !i_push) |=> (r_count + 1'b1 == $past(r_count)), "queue count did not drop on pop")

endmodule

FILE: sv/cau_back.sv
`timescale 1ns / 1ps
`include "complex_arithmetic_unit_assert.svh"

module cau_back import cau_pkg::*; #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  t_item                     i_item,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [FIELD_W-1:0] o_res_re,
    output logic signed [FIELD_W-1:0] o_res_im,
    output logic [STAT_W-1:0]         o_status
);

    localparam int MAXS = (FRAC_BITS > DATA_WIDTH) ? FRAC_BITS : DATA_WIDTH;
    localparam int RW   = MAG_W + 1 + MAXS;     // divider remainder width
    localparam int QW   = DATA_WIDTH + 1;       // quotient bits, one extra for rounding
    localparam int NSTG = QW;

    localparam logic [MAG_W:0]   HALF   = ((MAG_W + 1)'(1) << FRAC_BITS) >> 1;
    localparam logic [MAG_W-1:0] CAP    = MAG_W'(1) << DATA_WIDTH;
    localparam logic [MAG_W-1:0] MAXNEG = MAG_W'(1) << (DATA_WIDTH - 1);
    localparam logic [MAG_W-1:0] MAXPOS = MAXNEG - 1'b1;
    localparam logic [FIELD_W-1:0] OUT_MAX = MAXPOS[FIELD_W-1:0];
    localparam logic [FIELD_W-1:0] OUT_MIN = FIELD_W'(~MAXNEG + 1'b1);

    typedef struct packed {
        t_op                      op;
        logic signed [PROD_W-1:0] p1;
        logic signed [PROD_W-1:0] p2;
        logic signed [PROD_W-1:0] p3;
        logic signed [PROD_W-1:0] p4;
        logic signed [PROD_W-1:0] q1;
        logic signed [PROD_W-1:0] q2;
        logic signed [SUM_W-1:0]  l_re;
        logic signed [SUM_W-1:0]  l_im;
    } t_mstg;

    typedef struct packed {
        t_op                     op;
        logic signed [SUM_W-1:0] s_re;
        logic signed [SUM_W-1:0] s_im;
        logic [MAG_W-1:0]        den;
    } t_cstg;

    typedef struct packed {
        t_op              op;
        logic             dz;
        logic             neg_re;
        logic             neg_im;
        logic [MAG_W-1:0] mag_re;
        logic [MAG_W-1:0] mag_im;
        logic [MAG_W-1:0] den;
    } t_astg;

    typedef struct packed {
        logic             is_div;
        logic             dz;
        logic             neg_re;
        logic             neg_im;
        logic             ovf_re;
        logic             ovf_im;
        logic [MAG_W-1:0] mag_re;
        logic [MAG_W-1:0] mag_im;
        logic [MAG_W-1:0] den;
        logic [RW-1:0]    rem_re;
        logic [RW-1:0]    rem_im;
        logic [QW-1:0]    quo_re;
        logic [QW-1:0]    quo_im;
    } t_dstg;

    typedef struct packed {
        logic               sat;
        logic [FIELD_W-1:0] v;
    } t_part;

    logic  w_adv;
    t_mstg r_m, n_m;
    t_cstg r_c, n_c;
    t_astg r_a, n_a;
    t_dstg n_d0;
    t_dstg r_d  [0:NSTG];
    logic  r_dv [0:NSTG];
    logic  r_mv, r_cv, r_av;

    logic                      r_o_valid;
    logic signed [FIELD_W-1:0] r_o_re, r_o_im, n_o_re, n_o_im;
    t_status                   r_o_status, n_o_status;

    // Whole back end moves as one; the output register is the only hold point.
    assign w_adv   = !r_o_valid || i_ready;
    assign o_ready = w_adv;

    // Multiply stage.
    always_comb begin
        n_m.op   = i_item.op;
        n_m.p1   = $signed(i_item.p_re) * $signed(i_item.y_re);
        n_m.p2   = $signed(i_item.p_im) * $signed(i_item.y_im);
        n_m.p3   = $signed(i_item.p_im) * $signed(i_item.y_re);
        n_m.p4   = $signed(i_item.p_re) * $signed(i_item.y_im);
        n_m.q1   = $signed(i_item.y_re) * $signed(i_item.y_re);
        n_m.q2   = $signed(i_item.y_im) * $signed(i_item.y_im);
        n_m.l_re = '0;
        n_m.l_im = '0;
        case (i_item.op)
            OP_ADD: begin
                n_m.l_re = SUM_W'($signed(i_item.p_re)) + SUM_W'($signed(i_item.y_re));
                n_m.l_im = SUM_W'($signed(i_item.p_im)) + SUM_W'($signed(i_item.y_im));
            end
            OP_SUB: begin
                n_m.l_re = SUM_W'($signed(i_item.p_re)) - SUM_W'($signed(i_item.y_re));
                n_m.l_im = SUM_W'($signed(i_item.p_im)) - SUM_W'($signed(i_item.y_im));
            end
            OP_CONJ: begin
                n_m.l_re = SUM_W'($signed(i_item.p_re));
                n_m.l_im = -SUM_W'($signed(i_item.p_im));
            end
            default: ;
        endcase
    end

    // Combine stage: cross sums and divisor.
    always_comb begin
        n_c.op   = r_m.op;
        n_c.den  = r_m.q1[MAG_W-1:0] + r_m.q2[MAG_W-1:0];
        n_c.s_re = '0;
        n_c.s_im = '0;
        case (r_m.op) inside
            OP_MUL: begin
                n_c.s_re = SUM_W'($signed(r_m.p1)) - SUM_W'($signed(r_m.p2));
                n_c.s_im = SUM_W'($signed(r_m.p4)) + SUM_W'($signed(r_m.p3));
            end
            OP_DIV: begin
                n_c.s_re = SUM_W'($signed(r_m.p1)) + SUM_W'($signed(r_m.p2));
                n_c.s_im = SUM_W'($signed(r_m.p3)) - SUM_W'($signed(r_m.p4));
            end
            OP_ADD, OP_SUB, OP_CONJ: begin
                n_c.s_re = r_m.l_re;
                n_c.s_im = r_m.l_im;
            end
            default: ;
        endcase
    end

    // Sign/magnitude split.
    always_comb begin
        logic signed [SUM_W-1:0] abs_re;
        logic signed [SUM_W-1:0] abs_im;
        abs_re     = r_c.s_re[SUM_W-1] ? -r_c.s_re : r_c.s_re;
        abs_im     = r_c.s_im[SUM_W-1] ? -r_c.s_im : r_c.s_im;
        n_a.op     = r_c.op;
        n_a.dz     = (r_c.op == OP_DIV) && (r_c.den == '0);
        n_a.neg_re = r_c.s_re[SUM_W-1];
        n_a.neg_im = r_c.s_im[SUM_W-1];
        n_a.mag_re = abs_re[MAG_W-1:0];
        n_a.mag_im = abs_im[MAG_W-1:0];
        n_a.den    = r_c.den;
    end

    // Product rounding, divider setup and quotient overflow check.
    always_comb begin
        logic [MAG_W:0] rnd_re;
        logic [MAG_W:0] rnd_im;
        logic [RW-1:0]  lim;
        rnd_re = ({1'b0, r_a.mag_re} + HALF) >> FRAC_BITS;
        rnd_im = ({1'b0, r_a.mag_im} + HALF) >> FRAC_BITS;
        lim    = {{(RW - MAG_W){1'b0}}, r_a.den} << (DATA_WIDTH + 1);
        n_d0.is_div = (r_a.op == OP_DIV);
        n_d0.dz     = r_a.dz;
        n_d0.neg_re = r_a.neg_re;
        n_d0.neg_im = r_a.neg_im;
        n_d0.den    = r_a.den;
        n_d0.rem_re = {{(RW - MAG_W){1'b0}}, r_a.mag_re} << (FRAC_BITS + 1);
        n_d0.rem_im = {{(RW - MAG_W){1'b0}}, r_a.mag_im} << (FRAC_BITS + 1);
        n_d0.ovf_re = (n_d0.rem_re >= lim);
        n_d0.ovf_im = (n_d0.rem_im >= lim);
        n_d0.quo_re = '0;
        n_d0.quo_im = '0;
        n_d0.mag_re = r_a.mag_re;
        n_d0.mag_im = r_a.mag_im;
        if (r_a.op == OP_MUL) begin
            n_d0.mag_re = rnd_re[MAG_W-1:0];
            n_d0.mag_im = rnd_im[MAG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv     <= 1'b0;
            r_cv     <= 1'b0;
            r_av     <= 1'b0;
            r_dv[0]  <= 1'b0;
        end else if (w_adv) begin
            r_mv     <= i_valid;
            r_cv     <= r_mv;
            r_av     <= r_cv;
            r_dv[0]  <= r_av;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m    <= n_m;
            r_c    <= n_c;
            r_a    <= n_a;
            r_d[0] <= n_d0;
        end
    end

    // Restoring divider: one quotient bit per stage, both parts share the divisor.
    for (genvar k = 0; k < NSTG; k++) begin : g_div
        localparam int BIT = NSTG - 1 - k;
        logic [RW-1:0] dsh;
        t_dstg         n_d;

        always_comb begin
            dsh = {{(RW - MAG_W){1'b0}}, r_d[k].den} << BIT;
            n_d = r_d[k];
            if (r_d[k].rem_re >= dsh) begin
                n_d.rem_re      = r_d[k].rem_re - dsh;
                n_d.quo_re[BIT] = 1'b1;
            end
            if (r_d[k].rem_im >= dsh) begin
                n_d.rem_im      = r_d[k].rem_im - dsh;
                n_d.quo_im[BIT] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k+1] <= 1'b0;
            end else if (w_adv) begin
                r_dv[k+1] <= r_dv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_d[k+1] <= n_d;
            end
        end
    end

    function automatic t_part f_sat(input logic neg, input logic [MAG_W-1:0] fm);
        logic [MAG_W-1:0] m;
        logic [MAG_W-1:0] mn;
        t_part            r;
        r.sat = 1'b0;
        m     = fm;
        if (neg) begin
            if (fm > MAXNEG) begin
                m     = MAXNEG;
                r.sat = 1'b1;
            end
        end else if (fm > MAXPOS) begin
            m     = MAXPOS;
            r.sat = 1'b1;
        end
        mn  = ~m + 1'b1;
        r.v = neg ? mn[FIELD_W-1:0] : m[FIELD_W-1:0];
        return r;
    endfunction

    // Quotient rounding, saturation and status.
    always_comb begin
        logic [QW:0]      qr_re;
        logic [QW:0]      qr_im;
        logic [MAG_W-1:0] fm_re;
        logic [MAG_W-1:0] fm_im;
        t_part            pr;
        t_part            pi;
        qr_re = ({1'b0, r_d[NSTG].quo_re} + 1'b1) >> 1;
        qr_im = ({1'b0, r_d[NSTG].quo_im} + 1'b1) >> 1;
        fm_re = r_d[NSTG].mag_re;
        fm_im = r_d[NSTG].mag_im;
        if (r_d[NSTG].is_div) begin
            fm_re = r_d[NSTG].ovf_re ? CAP : {{(MAG_W - QW - 1){1'b0}}, qr_re};
            fm_im = r_d[NSTG].ovf_im ? CAP : {{(MAG_W - QW - 1){1'b0}}, qr_im};
        end
        pr = f_sat(r_d[NSTG].neg_re, fm_re);
        pi = f_sat(r_d[NSTG].neg_im, fm_im);
        if (r_d[NSTG].dz) begin
            n_o_re     = '0;
            n_o_im     = '0;
            n_o_status = ST_DIVZERO;
        end else begin
            n_o_re     = pr.v;
            n_o_im     = pi.v;
            n_o_status = (pr.sat || pi.sat) ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_adv) begin
            r_o_valid <= r_dv[NSTG];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_o_re     <= n_o_re;
            r_o_im     <= n_o_im;
            r_o_status <= n_o_status;
        end
    end

    assign o_valid  = r_o_valid;
    assign o_res_re = r_o_re;
    assign o_res_im = r_o_im;
    assign o_status = r_o_status;

    `CAU_ASSERT(a_b_divzero_zero, (r_o_valid && r_o_status == ST_DIVZERO) |-> (r_o_re == '0 && r_o_im == '0))
    `CAU_ASSERT_MSG(a_b_sat_at_rail, (r_o_valid && r_o_status == ST_SAT) |-> (r_o_re == OUT_MAX || r_o_re == OUT_MIN || r_o_im == OUT_MAX || r_o_im == OUT_MIN), "saturated status without a part at a rail")

endmodule

FILE: sv/complex_arithmetic_unit.sv
`timescale 1ns / 1ps
// Complex ALU in signed fixed point (Q16.16 by default): add, subtract,
// multiply, divide, conjugate of a, and inverse of a, one request per clock
// while i_ready is high. A request is accepted when i_valid and o_ready are
// both high; results appear in request order, and the pipeline sustains one
// request per cycle while i_ready is high. The restoring divider resolves one
// quotient bit per stage over DATA_WIDTH + 1 stages; every operation flows
// through the same pipe so ordering is kept. Products and quotients round to
// nearest with ties away from zero, each result part saturates to a signed
// DATA_WIDTH-bit range (status 1), and a zero divisor gives a zero result
// with status 2. Unused action codes return zero with status 0.
// DATA_WIDTH covers 16..32; the ports stay 32 bits wide.

module complex_arithmetic_unit import cau_pkg::*; #(
    parameter int DATA_WIDTH  = 32,
    parameter int FRAC_BITS   = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // request channel
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [ACT_W-1:0]          i_action,
    input  logic signed [FIELD_W-1:0] i_a_re,
    input  logic signed [FIELD_W-1:0] i_a_im,
    input  logic signed [FIELD_W-1:0] i_b_re,
    input  logic signed [FIELD_W-1:0] i_b_im,
    // result channel
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [FIELD_W-1:0] o_res_re,
    output logic signed [FIELD_W-1:0] o_res_im,
    output logic [STAT_W-1:0]         o_status
);

    t_item w_front_item;    // classified request
    t_item w_queue_item;    // head of queue
    logic  w_q_ready;
    logic  w_q_valid;
    logic  w_back_ready;

    // Front: map action code to an operation class and operand pair.
    // Inverse becomes (1 + 0i) / a so the back end sees only one divide form.
    cau_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_action (i_action),
        .i_a_re   (i_a_re),
        .i_a_im   (i_a_im),
        .i_b_re   (i_b_re),
        .i_b_im   (i_b_im),
        .o_item   (w_front_item)
    );

    // Short queue decouples request acceptance from back-end stalls.
    cau_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid && w_q_ready),
        .i_item  (w_front_item),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_item  (w_queue_item),
        .i_pop   (w_q_valid && w_back_ready)
    );

    assign o_ready = w_q_ready;

    // Back: multipliers, sums, pipelined divider, rounding and saturation.
    cau_back #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_q_valid),
        .o_ready  (w_back_ready),
        .i_item   (w_queue_item),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_res_re (o_res_re),
        .o_res_im (o_res_im),
        .o_status (o_status)
    );

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import cau_pkg::*;

    localparam int FRAC      = 16;
    localparam int SAT_W     = 32;
    localparam int N_RANDOM  = 1400;
    localparam int HOLD_AT   = 700;     // request count that starts the long stall
    localparam int HOLD_LEN  = 300;
    localparam int CALM_LO   = 200;     // request window with no idling on either side
    localparam int CALM_HI   = 420;
    localparam int WD_LIMIT  = 4000;
    localparam int DRAIN     = 60;      // pipe is 39 deep at the default width

    // spare action codes the block must answer with zero
    localparam logic [ACT_W-1:0] ACT_SPARE6 = 3'd6;
    localparam logic [ACT_W-1:0] ACT_SPARE7 = 3'd7;

    localparam logic [31:0] MAXP = 32'h7fff_ffff;
    localparam logic [31:0] MAXN = 32'h8000_0000;
    localparam logic [31:0] ONE  = 32'h0001_0000;

    typedef struct {
        logic [ACT_W-1:0] act;
        logic [31:0]      ar, ai, br, bi;
        bit               typed;        // expected result written in by hand
        logic [31:0]      er, ei;
        t_status          es;
    } t_req;

    typedef struct {
        logic [31:0] re, im;
        t_status     st;
    } t_cres;

    // sign-magnitude value, wide enough for every exact intermediate
    typedef struct {
        bit           neg;
        logic [127:0] mag;
    } t_smag;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      o_ready;
    logic [ACT_W-1:0]          i_action = '0;
    logic signed [FIELD_W-1:0] i_a_re = '0, i_a_im = '0, i_b_re = '0, i_b_im = '0;
    logic                      o_valid;
    logic                      i_ready = 1'b0;
    logic signed [FIELD_W-1:0] o_res_re, o_res_im;
    logic [STAT_W-1:0]         o_status;

    complex_arithmetic_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_action (i_action),
        .i_a_re   (i_a_re),
        .i_a_im   (i_a_im),
        .i_b_re   (i_b_re),
        .i_b_im   (i_b_im),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_res_re (o_res_re),
        .o_res_im (o_res_im),
        .o_status (o_status)
    );

    always #5 i_clk = ~i_clk;

    t_req  stim_q[$];       // every request to send, directed rows first
    t_req  inflight_q[$];   // requests offered, waiting for acceptance
    t_cres result_q[$];     // expected results in request order
    int    n_sent = 0;
    int    n_fail = 0;
    int    idle_cycles = 0;
    bit    stim_done = 1'b0;

    // ---------------- predictor ----------------
    function automatic t_smag sm(bit neg, logic [127:0] mag);
        t_smag r;
        r.neg = neg && (mag != 0);
        r.mag = mag;
        return r;
    endfunction

    function automatic t_smag from_field(logic [31:0] v);
        if (v[31]) return sm(1'b1, (128'd1 << 32) - {96'd0, v});
        return sm(1'b0, {96'd0, v});
    endfunction

    function automatic t_smag sm_plus(t_smag a, t_smag b);
        if (a.neg == b.neg) return sm(a.neg, a.mag + b.mag);
        if (a.mag >= b.mag) return sm(a.neg, a.mag - b.mag);
        return sm(b.neg, b.mag - a.mag);
    endfunction

    function automatic t_smag sm_times(t_smag a, t_smag b);
        return sm(a.neg != b.neg, a.mag * b.mag);
    endfunction

    function automatic t_smag sm_negate(t_smag a);
        return sm(!a.neg, a.mag);
    endfunction

    // drop the fraction bits, nearest with ties away from zero
    function automatic t_smag round_frac(t_smag a);
        return sm(a.neg, (a.mag + (128'd1 << (FRAC - 1))) >> FRAC);
    endfunction

    // num * 2^FRAC / den rounded to nearest, magnitude capped at 2^SAT_W
    function automatic t_smag fix_quotient(t_smag num, logic [127:0] den);
        logic [127:0] cap, q, r;
        bit           b;
        cap = 128'd1 << SAT_W;
        q = num.mag / den;
        r = num.mag % den;
        if (q > cap) q = cap;
        for (int k = 0; k < FRAC; k++) begin
            b = (r >= den - r);
            r = b ? r - (den - r) : r * 2;
            if (q < cap) q = q * 2 + b;
            if (q > cap) q = cap;
        end
        if (q < cap && r >= den - r) q = q + 1;
        return sm(num.neg, q);
    endfunction

    function automatic logic [31:0] clamp_part(t_smag v, inout bit hit);
        logic [127:0] lim, m;
        lim = 128'd1 << (SAT_W - 1);
        m = v.mag;
        if (!v.neg) begin
            if (m > lim - 1) begin
                m = lim - 1;
                hit = 1'b1;
            end
            return m[31:0];
        end
        if (m > lim) begin
            m = lim;
            hit = 1'b1;
        end
        m = -m;
        return m[31:0];
    endfunction

    function automatic t_cres predict_cplx(logic [ACT_W-1:0] act, logic [31:0] ar,
                                           logic [31:0] ai, logic [31:0] br,
                                           logic [31:0] bi);
        t_smag        xr, xi, yr, yi, rr, ri;
        logic [127:0] den;
        bit           hit, dz;
        t_cres        c;
        xr = from_field(ar);
        xi = from_field(ai);
        yr = from_field(br);
        yi = from_field(bi);
        rr = sm(1'b0, 0);
        ri = sm(1'b0, 0);
        hit = 1'b0;
        dz = 1'b0;
        case (act)
            ACT_ADD: begin
                rr = sm_plus(xr, yr);
                ri = sm_plus(xi, yi);
            end
            ACT_SUB: begin
                rr = sm_plus(xr, sm_negate(yr));
                ri = sm_plus(xi, sm_negate(yi));
            end
            ACT_MUL: begin
                rr = round_frac(sm_plus(sm_times(xr, yr), sm_negate(sm_times(xi, yi))));
                ri = round_frac(sm_plus(sm_times(xr, yi), sm_times(xi, yr)));
            end
            ACT_DIV, ACT_INV: begin
                // inverse: divide 1.0 by a
                if (act == ACT_INV) begin
                    yr = xr;
                    yi = xi;
                    xr = sm(1'b0, 128'd1 << FRAC);
                    xi = sm(1'b0, 0);
                end
                den = yr.mag * yr.mag + yi.mag * yi.mag;
                if (den == 0) begin
                    dz = 1'b1;
                end else begin
                    rr = fix_quotient(sm_plus(sm_times(xr, yr), sm_times(xi, yi)), den);
                    ri = fix_quotient(sm_plus(sm_times(xi, yr),
                                              sm_negate(sm_times(xr, yi))), den);
                end
            end
            ACT_CONJ: begin
                rr = xr;
                ri = sm_negate(xi);
            end
            default: ;
        endcase
        c.re = clamp_part(rr, hit);
        c.im = clamp_part(ri, hit);
        c.st = dz ? ST_DIVZERO : (hit ? ST_SAT : ST_OK);
        return c;
    endfunction

    // ---------------- stimulus ----------------
    function automatic t_req row(logic [ACT_W-1:0] act, logic [31:0] ar, logic [31:0] ai,
                                 logic [31:0] br, logic [31:0] bi);
        t_req r;
        r.act = act;
        r.ar = ar;
        r.ai = ai;
        r.br = br;
        r.bi = bi;
        r.typed = 1'b0;
        r.er = '0;
        r.ei = '0;
        r.es = ST_OK;
        return r;
    endfunction

    function automatic t_req row_exp(logic [ACT_W-1:0] act, logic [31:0] ar,
                                     logic [31:0] ai, logic [31:0] br, logic [31:0] bi,
                                     logic [31:0] er, logic [31:0] ei, t_status es);
        t_req r;
        r = row(act, ar, ai, br, bi);
        r.typed = 1'b1;
        r.er = er;
        r.ei = ei;
        r.es = es;
        return r;
    endfunction

    function automatic logic [31:0] pick_operand();
        logic [31:0] v;
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(6))
                    0: v = MAXP;
                    1: v = MAXN;
                    2: v = ONE;
                    3: v = -ONE;
                    4: v = 32'd1;
                    5: v = 32'hffff_ffff;
                    default: v = '0;
                endcase
            end
            1, 2, 3: v = $urandom;
            4, 5, 6: begin
                // a few units either way, keeps products in range
                v = $urandom_range(32'h0004_0000);
                if ($urandom_range(1)) v = -v;
            end
            7: v = $urandom_range(255) - 128;   // tiny fractions: stress inverse
            default: begin
                v = $urandom_range(32'h0100_0000);
                if ($urandom_range(1)) v = -v;
            end
        endcase
        return v;
    endfunction

    function automatic t_req random_req();
        t_req r;
        logic [ACT_W-1:0] act;
        act = ($urandom_range(19) == 0) ? ACT_W'($urandom_range(7)) : ACT_W'($urandom_range(5));
        r = row(act, pick_operand(), pick_operand(), pick_operand(), pick_operand());
        // zero divisor now and then
        if ($urandom_range(11) == 0) begin
            if (act == ACT_DIV) begin
                r.br = '0;
                r.bi = '0;
            end else if (act == ACT_INV) begin
                r.ar = '0;
                r.ai = '0;
            end
        end
        return r;
    endfunction

    initial begin
        // results that follow from the definition directly
        stim_q.push_back(row_exp(ACT_ADD, 0, 0, 0, 0, 0, 0, ST_OK));
        stim_q.push_back(row_exp(ACT_ADD, MAXP, 0, MAXP, 0, MAXP, 0, ST_SAT));
        stim_q.push_back(row_exp(ACT_ADD, 0, MAXN, 0, MAXN, 0, MAXN, ST_SAT));
        stim_q.push_back(row_exp(ACT_SUB, MAXN, 0, 32'd1, 0, MAXN, 0, ST_SAT));
        stim_q.push_back(row_exp(ACT_SUB, 0, MAXP, 0, 32'hffff_ffff, 0, MAXP, ST_SAT));
        stim_q.push_back(row_exp(ACT_MUL, ONE, 0, ONE, 0, ONE, 0, ST_OK));
        stim_q.push_back(row_exp(ACT_CONJ, MAXN, MAXN, 0, 0, MAXN, MAXP, ST_SAT));
        stim_q.push_back(row_exp(ACT_CONJ, MAXP, MAXP, 0, 0, MAXP, 32'h8000_0001, ST_OK));
        stim_q.push_back(row_exp(ACT_DIV, ONE, ONE, 0, 0, 0, 0, ST_DIVZERO));
        stim_q.push_back(row_exp(ACT_INV, 0, 0, ONE, ONE, 0, 0, ST_DIVZERO));
        stim_q.push_back(row_exp(ACT_INV, ONE, 0, 0, 0, ONE, 0, ST_OK));
        stim_q.push_back(row_exp(ACT_SPARE6, MAXP, MAXN, ONE, ONE, 0, 0, ST_OK));
        stim_q.push_back(row_exp(ACT_SPARE7, MAXN, MAXP, 1, 1, 0, 0, ST_OK));
        // left to the predictor
        stim_q.push_back(row(ACT_MUL, MAXN, MAXN, MAXN, MAXN));
        stim_q.push_back(row(ACT_MUL, MAXP, MAXN, MAXN, MAXP));
        stim_q.push_back(row(ACT_MUL, 32'h0000_8000, 0, 32'd1, 0));    // tie, rounds up
        stim_q.push_back(row(ACT_MUL, 32'hffff_8000, 0, 32'd1, 0));    // negative tie
        stim_q.push_back(row(ACT_DIV, MAXP, MAXN, 32'd1, 32'd1));
        stim_q.push_back(row(ACT_DIV, MAXN, MAXN, MAXN, MAXN));
        stim_q.push_back(row(ACT_DIV, ONE, 0, 32'h0003_0000, 0));      // 1/3
        stim_q.push_back(row(ACT_INV, 32'd1, 0, 0, 0));                // overflow
        stim_q.push_back(row(ACT_INV, MAXN, MAXN, 0, 0));
        stim_q.push_back(row(ACT_INV, 32'hffff_ffff, 32'd1, 0, 0));
        stim_q.push_back(row(ACT_SUB, MAXP, MAXN, MAXN, MAXP));
        for (int k = 0; k < N_RANDOM; k++) stim_q.push_back(random_req());
    end

    function automatic bit calm();
        return n_sent >= CALM_LO && n_sent < CALM_HI;
    endfunction

    // reset, then request driver; payload changes only at the falling edge
    initial begin
        t_req r;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        while (stim_q.size() > 0) begin
            r = stim_q.pop_front();
            while (!calm() && $urandom_range(99) < 25) begin
                i_valid <= 1'b0;
                @(negedge i_clk);
            end
            i_valid  <= 1'b1;
            i_action <= r.act;
            i_a_re   <= r.ar;
            i_a_im   <= r.ai;
            i_b_re   <= r.br;
            i_b_im   <= r.bi;
            inflight_q.push_back(r);
            do @(posedge i_clk); while (!o_ready);
            n_sent++;
            @(negedge i_clk);
        end
        i_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // result side: random back-pressure plus one long stall
    initial begin
        bit held;
        held = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && n_sent >= HOLD_AT) begin
                held = 1'b1;
                i_ready <= 1'b0;
                repeat (HOLD_LEN) @(negedge i_clk);
            end
            i_ready <= calm() || ($urandom_range(99) >= 25);
        end
    end

    // acceptance of both channels, checking and watchdog
    always @(posedge i_clk) begin
        t_req  r;
        t_cres c;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                r = inflight_q.pop_front();
                if (r.typed) begin
                    c.re = r.er;
                    c.im = r.ei;
                    c.st = r.es;
                end else begin
                    c = predict_cplx(i_action, i_a_re, i_a_im, i_b_re, i_b_im);
                end
                result_q.push_back(c);
            end
            if (o_valid && i_ready) begin
                if (result_q.size() == 0) begin
                    $display("%0t: unexpected result re=%h im=%h status=%0d",
                             $time, o_res_re, o_res_im, o_status);
                    n_fail++;
                end else begin
                    c = result_q.pop_front();
                    if (o_res_re !== c.re) begin
                        $display("%0t: res_re expected %h actual %h", $time, c.re, o_res_re);
                        n_fail++;
                    end
                    if (o_res_im !== c.im) begin
                        $display("%0t: res_im expected %h actual %h", $time, c.im, o_res_im);
                        n_fail++;
                    end
                    if (o_status !== c.st) begin
                        $display("%0t: status expected %0d actual %0d", $time, c.st, o_status);
                        n_fail++;
                    end
                end
            end
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WD_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        wait (stim_done);
        wait (result_q.size() == 0);
        repeat (DRAIN) @(posedge i_clk);
        if (n_fail == 0 && result_q.size() == 0) begin
            $display("status: pass");
        end else begin
            if (result_q.size() != 0)
                $display("%0t: %0d results never arrived", $time, result_q.size());
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/cau_pkg.sv
sv/cau_front.sv
sv/cau_queue.sv
sv/cau_back.sv
sv/complex_arithmetic_unit.sv
sim/tb_top.sv
